// ===== design/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types, widths and the restoring division step of the 3x3 inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned NumLanes = 9;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned CofW     = 65;
  localparam int unsigned CmagW    = 64;
  localparam int unsigned DetW     = 97;
  localparam int unsigned MagW     = 96;
  localparam int unsigned QW       = 32;
  localparam int unsigned EpsW     = 31;
  localparam int unsigned DvalW    = 64;

  typedef struct packed {
    logic signed [DataW-1:0] a00;
    logic signed [DataW-1:0] a01;
    logic signed [DataW-1:0] a02;
    logic signed [DataW-1:0] a10;
    logic signed [DataW-1:0] a11;
    logic signed [DataW-1:0] a12;
    logic signed [DataW-1:0] a20;
    logic signed [DataW-1:0] a21;
    logic signed [DataW-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] b00;
    logic signed [DataW-1:0] b01;
    logic signed [DataW-1:0] b02;
    logic signed [DataW-1:0] b10;
    logic signed [DataW-1:0] b11;
    logic signed [DataW-1:0] b12;
    logic signed [DataW-1:0] b20;
    logic signed [DataW-1:0] b21;
    logic signed [DataW-1:0] b22;
    logic signed [DvalW-1:0] det_value;
    logic                    singular;
  } out_t;

  typedef logic signed [CofW-1:0] cof_t;

  // per element divider state
  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [QW-1:0]   lq;
    logic            neg;
    logic            sat;
  } lane_t;

  // determinant side band, shared by all elements
  typedef struct packed {
    logic [MagW-1:0] dmag;
    logic            dneg;
    logic            singular;
    logic [DetW-1:0] drnd;
  } side_t;

  // one restoring step: shift in the next numerator bit, emit one quotient bit
  function automatic lane_t div_step(lane_t a, logic [MagW-1:0] d);
    logic [MagW:0] rs;
    logic          ge;
    lane_t         r;
    rs    = {a.rem, a.lq[QW-1]};
    ge    = rs >= {1'b0, d};
    r     = a;
    r.rem = ge ? MagW'(rs - {1'b0, d}) : MagW'(rs);
    r.lq  = {a.lq[QW-2:0], ge};
    return r;
  endfunction

endpackage

// ===== design/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 matrix inverse by cofactors in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle while the output does not stall and returns its
// inverse, determinant and a singular flag. The pipeline runs cofactors,
// determinant and divider setup, restoring division (one quotient bit per stage
// for all nine elements at once), then rounding and saturation. A stall on the
// output freezes the whole pipeline; otherwise a new transaction is taken
// every cycle. The epsilon register may be written only while the pipeline is
// empty.
module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [EpsW-1:0] cfg_data_i
);

  logic                    en;
  logic [EpsW-1:0]         eps_q;
  logic                    cof_valid, det_valid, div_valid;
  cof_t                    cof [NumLanes];
  logic signed [DataW-1:0] col0 [3];
  lane_t                   det_lane [NumLanes];
  lane_t                   div_lane [NumLanes];
  side_t                   det_side, div_side;

  // pipeline advances unless the output register holds an untaken result
  assign en          = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      eps_q <= cfg_data_i;
    end
  end

  mi3_cofactor u_cof (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .valid_o (cof_valid),
    .cof_o   (cof),
    .col0_o  (col0)
  );

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cof_valid),
    .cof_i   (cof),
    .col0_i  (col0),
    .eps_i   (eps_q),
    .valid_o (det_valid),
    .lane_o  (det_lane),
    .side_o  (det_side)
  );

  mi3_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .lane_i  (det_lane),
    .side_i  (det_side),
    .valid_o (div_valid),
    .lane_o  (div_lane),
    .side_o  (div_side)
  );

  mi3_finish u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .lane_i  (div_lane),
    .side_i  (div_side),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.b00 == 0 && out_data_o.b11 == 0 && out_data_o.b22 == 0 &&
      out_data_o.b01 == 0 && out_data_o.b12 == 0 && out_data_o.b20 == 0)
    else $error("singular transaction with nonzero inverse");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(det_valid) && $stable(div_valid))
    else $error("internal stage moved during output stall");

endmodule

// ===== design/mi3_cofactor.sv =====
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen minor products, then the nine cofactors.
// ----------------------------------------------------------------------------
module mi3_cofactor import mi3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  in_t                     mat_i,
  output logic                    valid_o,
  output cof_t                    cof_o [NumLanes],
  output logic signed [DataW-1:0] col0_o [3]
);

  logic signed [DataW-1:0] m [3][3];
  logic signed [ProdW-1:0] pp_q [NumLanes];
  logic signed [ProdW-1:0] pn_q [NumLanes];
  cof_t                    cof_q [NumLanes];
  logic signed [DataW-1:0] col1_q [3];
  logic signed [DataW-1:0] col2_q [3];
  logic [1:0]              vld_q;

  assign m[0][0] = mat_i.a00;
  assign m[0][1] = mat_i.a01;
  assign m[0][2] = mat_i.a02;
  assign m[1][0] = mat_i.a10;
  assign m[1][1] = mat_i.a11;
  assign m[1][2] = mat_i.a12;
  assign m[2][0] = mat_i.a20;
  assign m[2][1] = mat_i.a21;
  assign m[2][2] = mat_i.a22;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int R1 = (i + 1) % 3;
      localparam int R2 = (i + 2) % 3;
      localparam int C1 = (j + 1) % 3;
      localparam int C2 = (j + 2) % 3;
      localparam int K  = i * 3 + j;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pp_q[K]  <= ProdW'(m[R1][C1]) * ProdW'(m[R2][C2]);
          pn_q[K]  <= ProdW'(m[R1][C2]) * ProdW'(m[R2][C1]);
          cof_q[K] <= CofW'(pp_q[K]) - CofW'(pn_q[K]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        col1_q[i] <= m[i][0];
        col2_q[i] <= col1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign cof_o   = cof_q;
  assign col0_o  = col2_q;

endmodule

// ===== design/mi3_det.sv =====
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: determinant partial products, sum, magnitudes, then the
// singular test, determinant rounding and divider setup.
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  cof_t                    cof_i [NumLanes],
  input  logic signed [DataW-1:0] col0_i [3],
  input  logic [EpsW-1:0]         eps_i,
  output logic                    valid_o,
  output lane_t                   lane_o [NumLanes],
  output side_t                   side_o
);

  localparam int unsigned Sh   = 2 * FRAC_BITS;
  localparam int unsigned NumW = CmagW + Sh;

  logic signed [65:0]      lo_q [3];
  logic signed [ProdW-1:0] hi_q [3];
  cof_t                    c1_q [NumLanes];
  cof_t                    c2_q [NumLanes];
  logic signed [DetW-1:0]  det_q, det_d;
  logic [MagW-1:0]         dmag_q;
  logic                    dneg_q;
  logic [CmagW-1:0]        cmag_q [NumLanes];
  logic                    cneg_q [NumLanes];
  lane_t                   lane_q [NumLanes];
  side_t                   side_q;
  logic [3:0]              vld_q;

  // a * c split as a * c[64:33] and a * c[32:0]
  for (genvar i = 0; i < 3; i++) begin : g_dp
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[i] <= 66'(col0_i[i]) * $signed({33'b0, cof_i[i*3][32:0]});
        hi_q[i] <= ProdW'(col0_i[i]) * ProdW'($signed(cof_i[i*3][CofW-1:33]));
      end
    end
  end

  always_comb begin
    det_d = '0;
    for (int i = 0; i < 3; i++) begin
      det_d = det_d + (DetW'(hi_q[i]) <<< 33) + DetW'(lo_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q   <= cof_i;
      c2_q   <= c1_q;
      det_q  <= det_d;
      dneg_q <= det_q[DetW-1];
      dmag_q <= det_q[DetW-1] ? MagW'(-det_q) : MagW'(det_q);
      side_q.dmag     <= dmag_q;
      side_q.dneg     <= dneg_q;
      side_q.singular <= dmag_q <= (MagW'(eps_i) << Sh);
      side_q.drnd     <= (DetW'(dmag_q) + (DetW'(1) << (Sh - 1))) >> Sh;
    end
  end

  // lane i*3+j divides the transposed cofactor C[j][i]
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    localparam int Src = (l % 3) * 3 + (l / 3);
    logic [NumW-1:0] num;
    assign num = {cmag_q[l], {Sh{1'b0}}};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cneg_q[l] <= c2_q[Src][CofW-1];
        cmag_q[l] <= c2_q[Src][CofW-1] ? CmagW'(-c2_q[Src]) : CmagW'(c2_q[Src]);
        lane_q[l].rem <= MagW'(num[NumW-1:QW]);
        lane_q[l].lq  <= num[QW-1:0];
        lane_q[l].neg <= cneg_q[l] ^ dneg_q;
        // quotient at or above 2^32 always saturates
        lane_q[l].sat <= 128'(num) >= {dmag_q, {QW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign lane_o  = lane_q;
  assign side_o  = side_q;

  a_nonsing_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_q.singular |-> side_q.dmag != '0)
    else $error("non-singular matrix with zero determinant");

endmodule

// ===== design/mi3_divider.sv =====
// ----------------------------------------------------------------------------
// mi3_divider
// Restoring divider for all nine elements, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mi3_divider import mi3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  lane_t lane_i [NumLanes],
  input  side_t side_i,
  output logic  valid_o,
  output lane_t lane_o [NumLanes],
  output side_t side_o
);

  lane_t           st_q   [QW][NumLanes];
  side_t           side_q [QW];
  logic [QW-1:0]   vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    lane_t src_l [NumLanes];
    side_t src_s;
    if (s == 0) begin : g_first
      assign src_l = lane_i;
      assign src_s = side_i;
    end else begin : g_next
      assign src_l = st_q[s-1];
      assign src_s = side_q[s-1];
    end
    for (genvar l = 0; l < NumLanes; l++) begin : g_l
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[s][l] <= div_step(src_l[l], src_s.dmag);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= src_s;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[QW-1];
  assign lane_o  = st_q[QW-1];
  assign side_o  = side_q[QW-1];

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !st_q[QW-1][0].sat |-> st_q[QW-1][0].rem < side_q[QW-1].dmag)
    else $error("divider remainder not below divisor");

endmodule

// ===== design/mi3_finish.sv =====
// ----------------------------------------------------------------------------
// mi3_finish
// Rounds the quotients, saturates, applies signs and the singular zeroing;
// the second stage is the output register.
// ----------------------------------------------------------------------------
module mi3_finish import mi3_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  lane_t lane_i [NumLanes],
  input  side_t side_i,
  output logic  valid_o,
  output out_t  data_o
);

  logic [QW:0]             q_q   [NumLanes];
  logic                    neg_q [NumLanes];
  logic                    sat_q [NumLanes];
  side_t                   side_q;
  logic signed [DataW-1:0] b     [NumLanes];
  logic [DvalW-1:0]        dlim, dv;
  out_t                    out_d, out_q;
  logic [1:0]              vld_q;

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    logic       inc;
    logic [QW:0] lim, v;
    // round half away from zero on the magnitude
    assign inc = {lane_i[l].rem, 1'b0} >= {1'b0, side_i.dmag};
    assign lim = neg_q[l] ? (33'd1 << (QW - 1)) : ((33'd1 << (QW - 1)) - 33'd1);
    assign v   = (sat_q[l] || q_q[l] > lim) ? lim : q_q[l];
    assign b[l] = side_q.singular ? '0 :
                  (neg_q[l] ? DataW'(-v) : DataW'(v));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[l]   <= {1'b0, lane_i[l].lq} + (QW+1)'(inc);
        neg_q[l] <= lane_i[l].neg;
        sat_q[l] <= lane_i[l].sat;
      end
    end
  end

  always_comb begin
    dlim = side_q.dneg ? (64'd1 << (DvalW - 1)) : ((64'd1 << (DvalW - 1)) - 64'd1);
    dv   = (side_q.drnd > DetW'(dlim)) ? dlim : side_q.drnd[DvalW-1:0];
    out_d.b00 = b[0];
    out_d.b01 = b[1];
    out_d.b02 = b[2];
    out_d.b10 = b[3];
    out_d.b11 = b[4];
    out_d.b12 = b[5];
    out_d.b20 = b[6];
    out_d.b21 = b[7];
    out_d.b22 = b[8];
    out_d.det_value = side_q.dneg ? -dv : dv;
    out_d.singular  = side_q.singular;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      out_q  <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign valid_o = vld_q[1];
  assign data_o  = out_q;

endmodule

// ===== test/matrix_inverse_3x3_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Self-checking bench for the 3x3 cofactor matrix inverter.
// ----------------------------------------------------------------------------
// Matrices are sent in random bursts while the output side stalls on its own
// pattern. Each accepted matrix is inverted here with exact wide integer
// arithmetic, and every returned transaction is compared field by field with
// the oldest pending inverse. The epsilon register is rewritten between phases
// while the pipeline is drained.
module matrix_inverse_3x3_tb;
  import mi3_pkg::*;

  localparam int FB = 16;
  localparam int PipeDepth = 45;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [EpsW-1:0] cfg_data_i = '0;

  logic [EpsW-1:0] eps_model;
  out_t            pending_inverses[$];
  int              errors = 0;

  always #1 clk_i = ~clk_i;

  matrix_inverse_3x3 #(.FRAC_BITS(FB)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // exact inverse: cofactors and determinant in 128 bits, one rounding at the end
  function automatic out_t invert_matrix(in_t m, logic [EpsW-1:0] eps);
    logic signed [127:0] a[3][3];
    logic signed [127:0] cof[3][3];
    logic signed [127:0] det;
    logic [127:0]        dmag, cmag, num, q, r, rnd, lim, thr;
    logic [31:0]         b[9];
    logic [63:0]         dval;
    logic                dneg, neg, sing;
    int                  r1, r2, c1, c2;
    for (int k = 0; k < 9; k++) begin
      a[k/3][k%3] = $signed(m[287-32*k -: 32]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r1 = (i + 1) % 3; r2 = (i + 2) % 3;
        c1 = (j + 1) % 3; c2 = (j + 2) % 3;
        cof[i][j] = a[r1][c1] * a[r2][c2] - a[r1][c2] * a[r2][c1];
      end
    end
    det = a[0][0] * cof[0][0] + a[1][0] * cof[1][0] + a[2][0] * cof[2][0];
    dneg = det < 0;
    dmag = dneg ? -det : det;
    rnd = (dmag + (128'd1 << (2*FB-1))) >> (2*FB);
    lim = dneg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
    if (rnd > lim) rnd = lim;
    dval = dneg ? -rnd[63:0] : rnd[63:0];
    thr = {97'd0, eps} << (2*FB);
    sing = dmag <= thr;
    for (int k = 0; k < 9; k++) begin
      b[k] = '0;
      if (!sing) begin
        // element (i,j) uses the transposed cofactor (j,i)
        cmag = cof[k%3][k/3] < 0 ? -cof[k%3][k/3] : cof[k%3][k/3];
        num = cmag << (2*FB);
        q = num / dmag;
        r = num % dmag;
        if ((r << 1) >= dmag) q = q + 1;
        neg = ((cof[k%3][k/3] < 0) != dneg) && (q != 0);
        lim = neg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
        if (q > lim) q = lim;
        b[k] = neg ? -q[31:0] : q[31:0];
      end
    end
    return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], dval, sing};
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("unexpected transaction", out_data_o.det_value, 64'd0);
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (out_data_o[352-32*k -: 32] !== want[352-32*k -: 32])
            report_mismatch($sformatf("b%0d%0d", k/3, k%3),
                            64'(out_data_o[352-32*k -: 32]),
                            64'(want[352-32*k -: 32]));
        end
        if (out_data_o.det_value !== want.det_value)
          report_mismatch("det_value", out_data_o.det_value, want.det_value);
        if (out_data_o.singular !== want.singular)
          report_mismatch("singular", 64'(out_data_o.singular), 64'(want.singular));
      end
    end
  end

  // output stall pattern: runs of stall or flow of random length
  always @(negedge clk_i) begin
    int run;
    if (run == 0) begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      run = $urandom_range(1, 24);
    end else begin
      run--;
    end
  end

  task automatic send_matrix(in_t m);
    in_valid_i = 1'b1;
    in_data_i  = m;
    do @(posedge clk_i); while (in_stall_o);
    pending_inverses.push_back(invert_matrix(m, eps_model));
    @(negedge clk_i);
  endtask

  task automatic write_eps(logic [EpsW-1:0] value);
    in_valid_i = 1'b0;
    while (pending_inverses.size() != 0) @(negedge clk_i);
    repeat (PipeDepth) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    eps_model = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_element(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  function automatic in_t random_matrix();
    logic [31:0] e[9];
    int mode;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      e[k] = pick_element(mode < 3 ? 0 : mode < 7 ? 1 : mode < 8 ? 2 : 3);
    end
    // near singular: third row close to the sum of the first two
    if (mode == 6) begin
      for (int k = 0; k < 3; k++) e[6+k] = e[k] + e[3+k] + $urandom_range(0, 3) - 1;
    end
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic test_directed();
    localparam logic [31:0] One = 32'h0001_0000;
    localparam logic [31:0] Mx = 32'h7fff_ffff;
    localparam logic [31:0] Mn = 32'h8000_0000;
    send_matrix({One, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, 32'd0, One});
    send_matrix('0);
    send_matrix({9{Mx}});
    send_matrix({9{Mn}});
    send_matrix({Mn, 32'd0, 32'd0, 32'd0, Mn, 32'd0, 32'd0, 32'd0, Mn});
    send_matrix({Mx, 32'd0, 32'd0, 32'd0, Mx, 32'd0, 32'd0, 32'd0, Mx});
    // determinant beyond 64 bits
    send_matrix({Mn, Mn, Mn, Mn, Mx, Mn, Mn, Mn, Mx});
    send_matrix({Mx, Mx, Mx, Mx, Mn, Mx, Mx, Mx, Mn});
    // tiny determinant: singular at the reset threshold, saturated inverse with epsilon zero
    send_matrix({32'd2, 32'd0, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd2});
    send_matrix({32'd2, 32'd0, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0, 32'd0, -32'd2});
    // determinant exactly at the reset threshold of one lsb and just above
    send_matrix({One, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd1});
    send_matrix({One, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd2});
    send_matrix({One, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd3});
    send_matrix({32'h0002_0000, One, 32'd0, One, 32'h0002_0000, One,
                 32'd0, One, 32'h0002_0000});
    send_matrix({32'hffff_0000, 32'h0003_0000, 32'h0000_8000, 32'h0001_8000,
                 32'hfffe_0000, 32'h0000_4000, 32'h0000_2000, 32'h0000_1000, One});
    in_valid_i = 1'b0;
  endtask

  task automatic test_random(int count);
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid_i = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst = $urandom_range(1, 30);
      end
      burst--;
      send_matrix(random_matrix());
    end
    in_valid_i = 1'b0;
  endtask

  initial begin
    eps_model = EpsW'(1);
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    write_eps('0);
    test_directed();
    test_random(400);
    write_eps({EpsW{1'b1}});
    test_random(300);
    write_eps(EpsW'($urandom_range(0, 1 << 20)));
    test_random(400);
    write_eps(EpsW'(1));
    test_random(550);
    while (pending_inverses.size() != 0) @(negedge clk_i);
    repeat (PipeDepth) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
